@@ hdl/tccs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccs_pkg
// Shared types and constants for the text console cursor/scroll engine.
// ----------------------------------------------------------------------------
package tccs_pkg;

    localparam int IN_W   = 40;
    localparam int OUT_W  = 40;
    localparam int CFG_W  = 4;
    localparam int COL_W  = 8;
    localparam int ROW_W  = 6;
    localparam int LIN_W  = 14;
    localparam int CELL_W = 16;

    typedef enum logic [1:0] {
        CMD_PUT   = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_SET   = 2'd2,
        CMD_READ  = 2'd3
    } t_cmd;

    typedef enum logic [0:0] {
        REG_FG = 1'b0,
        REG_BG = 1'b1
    } t_reg;

    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_BS      = 8'h08;
    localparam logic [7:0] CH_BLANK   = 8'h20;
    localparam logic [7:0] RESET_ATTR = 8'h07;
    localparam logic [8:0] TAB_STEP   = 9'd8;
    localparam logic [8:0] TAB_MASK   = ~9'd7;

    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             wr;
        logic [COL_W-1:0] wr_col;
        logic [7:0]       wr_char;
        logic             scroll;
    } t_cur_upd;

endpackage

@@ hdl/text_console_cursor_scroll.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_cursor_scroll
// Text console engine: cell store in a RAM, cursor, scroll and clear walks.
//
//  channel   dir  fields (lsb first)
//  s_axis    in   command[1:0] char_code[9:2] target_col[17:10]
//                 target_row[25:18] read_address[36:26]
//  m_axis    out  cursor_col_out[6:0] cursor_row_out[11:7]
//                 cursor_linear[22:12] cell_data[38:23]
//  cfg       in   0 foreground_colour, 1 background_colour
//
// Plain put and set cursor go from execute straight to done; read cell adds
// a wait for the registered RAM read. Put with scroll copies each cell up one
// row over the single RAM read port, then fills the bottom row. Clear screen
// fills every cell. After reset the RAM is swept to blanks, tready low.
// A finished request waits in the output register; a stalled output only
// holds the engine once the next result is ready.
// ----------------------------------------------------------------------------
module text_console_cursor_scroll #(
    parameter int COLS = 80,
    parameter int ROWS = 25
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [tccs_pkg::IN_W-1:0]  s_axis_tdata,  // command, char_code, target_col,
                                                       // target_row, read_address
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [tccs_pkg::OUT_W-1:0] m_axis_tdata,  // cursor_col_out, cursor_row_out,
                                                       // cursor_linear, cell_data
    input  logic                       i_cfg_we,
    input  logic [0:0]                 i_cfg_idx,
    input  logic [tccs_pkg::CFG_W-1:0] i_cfg_data
);
    import tccs_pkg::*;

    localparam int CELLS     = COLS * ROWS;
    localparam int AW        = $clog2(CELLS);
    localparam int LAST_CELL = CELLS - 1;
    localparam int COPY_LAST = CELLS - COLS - 1;

    typedef enum logic [2:0] {
        ST_INIT, ST_IDLE, ST_EXEC, ST_RDWAIT, ST_SCROLL, ST_DRAIN, ST_FILL, ST_DONE
    } t_state;

    t_state             r_state;
    logic [AW-1:0]      r_idx;
    logic               r_pend;
    logic [AW-1:0]      r_pend_idx;
    logic [COL_W-1:0]   r_col;
    logic [ROW_W-1:0]   r_row;
    logic [3:0]         r_fg;
    logic [3:0]         r_bg;
    logic [1:0]         r_cmd;
    logic [7:0]         r_ch;
    logic [7:0]         r_tcol;
    logic [7:0]         r_trow;
    logic [10:0]        r_addr;
    logic               r_rd_ok;
    logic [CELL_W-1:0]  r_cell;
    logic               r_out_valid;
    logic [OUT_W-1:0]   r_out_data;

    t_cur_upd           upd;
    logic [7:0]         attr;
    logic [LIN_W-1:0]   lin;
    logic [LIN_W-1:0]   wr_lin;
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [CELL_W-1:0]  mem_wdata;
    logic [AW-1:0]      mem_raddr;
    logic [CELL_W-1:0]  mem_rdata;
    logic               addr_ok;

    assign attr    = {r_bg, r_fg};
    assign lin     = LIN_W'(r_row) * LIN_W'(COLS) + LIN_W'(r_col);
    assign wr_lin  = LIN_W'(r_row) * LIN_W'(COLS) + LIN_W'(upd.wr_col);
    assign addr_ok = LIN_W'(r_addr) < LIN_W'(CELLS);

    tccs_cursor #(
        .COLS(COLS),
        .ROWS(ROWS)
    ) u_cursor (
        .i_cmd (r_cmd),
        .i_char(r_ch),
        .i_tcol(r_tcol),
        .i_trow(r_trow),
        .i_col (r_col),
        .i_row (r_row),
        .o_upd (upd)
    );

    tccs_ram #(
        .WIDTH(CELL_W),
        .DEPTH(CELLS)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_raddr(mem_raddr),
        .o_rdata(mem_rdata)
    );

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_idx;
        mem_wdata = {attr, CH_BLANK};
        mem_raddr = r_idx + AW'(COLS);
        case (r_state)
            ST_INIT: begin
                mem_we    = 1'b1;
                mem_wdata = {RESET_ATTR, CH_BLANK};
            end
            ST_EXEC: begin
                mem_we    = (t_cmd'(r_cmd) == CMD_PUT) && upd.wr;
                mem_waddr = wr_lin[AW-1:0];
                mem_wdata = {attr, upd.wr_char};
                mem_raddr = AW'(r_addr);
            end
            ST_SCROLL, ST_DRAIN: begin
                mem_we    = r_pend;
                mem_waddr = r_pend_idx;
                mem_wdata = mem_rdata;
            end
            ST_FILL: begin
                mem_we = 1'b1;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_idx       <= '0;
            r_pend      <= 1'b0;
            r_col       <= '0;
            r_row       <= '0;
            r_fg        <= 4'd7;
            r_bg        <= 4'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (t_reg'(i_cfg_idx))
                    REG_FG:  r_fg <= i_cfg_data;
                    REG_BG:  r_bg <= i_cfg_data;
                    default: r_fg <= r_fg;
                endcase
            end

            if (r_state == ST_DONE && (!r_out_valid || m_axis_tready)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_INIT: begin
                    if (r_idx == AW'(LAST_CELL)) begin
                        r_idx   <= '0;
                        r_state <= ST_IDLE;
                    end else begin
                        r_idx <= r_idx + AW'(1);
                    end
                end
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_cmd   <= s_axis_tdata[1:0];
                        r_ch    <= s_axis_tdata[9:2];
                        r_tcol  <= s_axis_tdata[17:10];
                        r_trow  <= s_axis_tdata[25:18];
                        r_addr  <= s_axis_tdata[36:26];
                        r_state <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    r_col   <= upd.col;
                    r_row   <= upd.row;
                    r_cell  <= '0;
                    r_idx   <= '0;
                    r_pend  <= 1'b0;
                    r_rd_ok <= addr_ok;
                    case (t_cmd'(r_cmd))
                        CMD_PUT:   r_state <= upd.scroll ? ST_SCROLL : ST_DONE;
                        CMD_CLEAR: r_state <= ST_FILL;
                        CMD_READ:  r_state <= ST_RDWAIT;
                        default:   r_state <= ST_DONE;
                    endcase
                end
                ST_RDWAIT: begin
                    r_cell  <= r_rd_ok ? mem_rdata : '0;
                    r_state <= ST_DONE;
                end
                ST_SCROLL: begin
                    r_pend     <= 1'b1;
                    r_pend_idx <= r_idx;
                    r_idx      <= r_idx + AW'(1);
                    if (r_idx == AW'(COPY_LAST)) begin
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    r_pend  <= 1'b0;
                    r_state <= ST_FILL;
                end
                ST_FILL: begin
                    if (r_idx == AW'(LAST_CELL)) begin
                        r_idx   <= '0;
                        r_state <= ST_DONE;
                    end else begin
                        r_idx <= r_idx + AW'(1);
                    end
                end
                ST_DONE: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE && (!r_out_valid || m_axis_tready)) begin
            r_out_data <= {1'b0, r_cell, lin[10:0], r_row[4:0], r_col[6:0]};
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (LIN_W'(r_col) < LIN_W'(COLS)) && (LIN_W'(r_row) < LIN_W'(ROWS)))
        else $error("cursor out of screen range");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request accepted while busy");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(r_state == ST_DONE))
        else $error("result issued outside completion");

    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !mem_we)
        else $error("cell store written while idle");

endmodule

@@ hdl/tccs_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccs_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module tccs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/tccs_cursor.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccs_cursor
// Next-cursor logic: control characters, wrap, clamping and cell write request.
// ----------------------------------------------------------------------------
module tccs_cursor #(
    parameter int COLS = 80,
    parameter int ROWS = 25
) (
    input  logic [1:0]                 i_cmd,
    input  logic [7:0]                 i_char,
    input  logic [7:0]                 i_tcol,
    input  logic [7:0]                 i_trow,
    input  logic [tccs_pkg::COL_W-1:0] i_col,
    input  logic [tccs_pkg::ROW_W-1:0] i_row,
    output tccs_pkg::t_cur_upd         o_upd
);
    import tccs_pkg::*;

    logic [8:0]       tab_col;
    logic [8:0]       inc_col;
    logic [8:0]       col9;
    logic             adv_row;
    logic [ROW_W:0]   row_nx;

    assign tab_col = ({1'b0, i_col} + TAB_STEP) & TAB_MASK;
    assign inc_col = {1'b0, i_col} + 9'd1;

    always_comb begin
        col9    = {1'b0, i_col};
        adv_row = 1'b0;
        o_upd   = '0;
        o_upd.wr_col  = i_col;
        o_upd.wr_char = i_char;
        if (i_char == CH_LF) begin
            col9    = '0;
            adv_row = 1'b1;
        end else if (i_char == CH_CR) begin
            col9 = '0;
        end else if (i_char == CH_TAB) begin
            if (tab_col >= 9'(COLS)) begin
                col9    = '0;
                adv_row = 1'b1;
            end else begin
                col9 = tab_col;
            end
        end else if (i_char == CH_BS) begin
            if (i_col != '0) begin
                col9          = {1'b0, i_col} - 9'd1;
                o_upd.wr      = 1'b1;
                o_upd.wr_col  = i_col - COL_W'(1);
                o_upd.wr_char = CH_BLANK;
            end
        end else begin
            o_upd.wr = 1'b1;
            if (inc_col >= 9'(COLS)) begin
                col9    = '0;
                adv_row = 1'b1;
            end else begin
                col9 = inc_col;
            end
        end

        row_nx = {1'b0, i_row} + {{ROW_W{1'b0}}, adv_row};

        case (t_cmd'(i_cmd))
            CMD_PUT: begin
                o_upd.col    = col9[COL_W-1:0];
                o_upd.scroll = (row_nx >= (ROW_W+1)'(ROWS));
                o_upd.row    = o_upd.scroll ? ROW_W'(ROWS-1) : row_nx[ROW_W-1:0];
            end
            CMD_CLEAR: begin
                o_upd.col = '0;
                o_upd.row = '0;
                o_upd.wr  = 1'b0;
            end
            CMD_SET: begin
                o_upd.col = ({1'b0, i_tcol} >= 9'(COLS)) ? COL_W'(COLS-1) : i_tcol;
                o_upd.row = (i_trow >= 8'(ROWS)) ? ROW_W'(ROWS-1) : i_trow[ROW_W-1:0];
                o_upd.wr  = 1'b0;
            end
            default: begin
                o_upd.col = i_col;
                o_upd.row = i_row;
                o_upd.wr  = 1'b0;
            end
        endcase
    end

endmodule

@@ tb/tb_text_console_cursor_scroll.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_text_console_cursor_scroll
// Self-checking bench for the text console engine. A queue of commands feeds
// a stream driver; every accepted request is run through a local screen and
// cursor model, and the predicted cursor/linear/cell words are compared with
// what the engine returns. A short directed pass covers control characters,
// wraps, scrolls, clamping and out-of-range reads; then random phases run
// under different colour settings, each phase drained before the registers
// change. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module tb_text_console_cursor_scroll;
    import tccs_pkg::*;

    localparam int COLS        = 80;
    localparam int ROWS        = 25;
    localparam int CELLS       = COLS * ROWS;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 284;
    localparam int MAX_SHOWN   = 10;

    typedef struct packed {
        t_cmd        cmd;
        logic [7:0]  ch;
        logic [7:0]  tcol;
        logic [7:0]  trow;
        logic [10:0] addr;
    } t_console_req;

    typedef struct packed {
        logic [6:0]  col;
        logic [4:0]  row;
        logic [10:0] lin;
        logic [15:0] glyph;
    } t_console_rsp;

    logic             i_clk         = 1'b0;
    logic             i_rst_n       = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [IN_W-1:0]  s_axis_tdata  = '0;  // command, char_code, target_col,
                                           // target_row, read_address
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [OUT_W-1:0] m_axis_tdata;        // cursor_col_out, cursor_row_out,
                                           // cursor_linear, cell_data
    logic             i_cfg_we      = 1'b0;
    logic [0:0]       i_cfg_idx     = REG_FG;
    logic [CFG_W-1:0] i_cfg_data    = '0;

    text_console_cursor_scroll #(
        .COLS(COLS),
        .ROWS(ROWS)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // screen and cursor model
    logic [15:0] screen_model [0:CELLS-1];
    int unsigned cur_col;
    int unsigned cur_row;
    logic [3:0]  fg_colour;
    logic [3:0]  bg_colour;

    t_console_req pending_reqs[$];
    t_console_rsp expected_rsps[$];
    int unsigned  reqs_issued     = 0;
    int unsigned  results_checked = 0;
    int unsigned  err_cnt         = 0;

    function automatic logic [15:0] colour_glyph(input logic [7:0] ch);
        return {bg_colour, fg_colour, ch};
    endfunction

    task automatic fill_screen(input int unsigned from, input logic [15:0] value);
        for (int i = from; i < CELLS; i++) screen_model[i] = value;
    endtask

    task automatic put_char_model(input logic [7:0] ch);
        if (ch == CH_LF) begin
            cur_col = 0;
            cur_row++;
        end else if (ch == CH_CR) begin
            cur_col = 0;
        end else if (ch == CH_TAB) begin
            cur_col = (cur_col + 8) & ~32'd7;
            if (cur_col >= COLS) begin
                cur_col = 0;
                cur_row++;
            end
        end else if (ch == CH_BS) begin
            if (cur_col > 0) begin
                cur_col--;
                screen_model[cur_row * COLS + cur_col] = colour_glyph(CH_BLANK);
            end
        end else begin
            screen_model[cur_row * COLS + cur_col] = colour_glyph(ch);
            cur_col++;
            if (cur_col >= COLS) begin
                cur_col = 0;
                cur_row++;
            end
        end
        if (cur_row >= ROWS) begin
            for (int i = 0; i < CELLS - COLS; i++) screen_model[i] = screen_model[i + COLS];
            fill_screen(CELLS - COLS, colour_glyph(CH_BLANK));
            cur_row = ROWS - 1;
        end
    endtask

    task automatic predict_console(input t_console_req rq, output t_console_rsp rs);
        logic [15:0] data;
        int unsigned lin;
        data = '0;
        case (rq.cmd)
            CMD_PUT: put_char_model(rq.ch);
            CMD_CLEAR: begin
                fill_screen(0, colour_glyph(CH_BLANK));
                cur_col = 0;
                cur_row = 0;
            end
            CMD_SET: begin
                cur_col = (rq.tcol >= COLS) ? COLS - 1 : rq.tcol;
                cur_row = (rq.trow >= ROWS) ? ROWS - 1 : rq.trow;
            end
            default: begin
                if (rq.addr < CELLS) data = screen_model[rq.addr];
            end
        endcase
        lin = cur_row * COLS + cur_col;
        rs.col   = cur_col[6:0];
        rs.row   = cur_row[4:0];
        rs.lin   = lin[10:0];
        rs.glyph = data;
    endtask

    function automatic t_console_req make_req(input t_cmd cmd, input logic [7:0] ch,
                                              input logic [7:0] tcol, input logic [7:0] trow,
                                              input logic [10:0] addr);
        t_console_req rq;
        rq.cmd  = cmd;
        rq.ch   = ch;
        rq.tcol = tcol;
        rq.trow = trow;
        rq.addr = addr;
        return rq;
    endfunction

    function automatic t_console_req random_req();
        t_console_req rq;
        int unsigned  pick;
        int unsigned  sub;
        rq.cmd  = CMD_PUT;
        rq.ch   = 8'($urandom_range(255));
        rq.tcol = 8'($urandom_range(255));
        rq.trow = 8'($urandom_range(255));
        rq.addr = 11'($urandom_range(2047));
        pick    = $urandom_range(99);
        sub     = $urandom_range(99);
        if (pick < 72) begin
            if (sub < 8)       rq.ch = CH_LF;
            else if (sub < 11) rq.ch = CH_CR;
            else if (sub < 16) rq.ch = CH_TAB;
            else if (sub < 22) rq.ch = CH_BS;
        end else if (pick < 84) begin
            rq.cmd = CMD_SET;
            if (sub < 50) rq.tcol = 8'($urandom_range(COLS - 1));
            if ($urandom_range(99) < 60) rq.trow = 8'($urandom_range(ROWS - 1));
        end else if (pick < 97) begin
            rq.cmd = CMD_READ;
            if (sub < 50)      rq.addr = 11'($urandom_range(CELLS - 1));
            else if (sub < 80) rq.addr = 11'($urandom_range(CELLS - 1, CELLS - 4 * COLS));
        end else begin
            rq.cmd = CMD_CLEAR;
        end
        return rq;
    endfunction

    function automatic int unsigned pick_gap(input bit burst);
        int unsigned r;
        r = $urandom_range(99);
        if (burst || r < 55) return 0;
        if (r < 88) return $urandom_range(3, 1);
        if (r < 97) return $urandom_range(20, 4);
        return $urandom_range(200, 50);
    endfunction

    // request driver
    t_console_req in_flight;
    int unsigned  tx_gap   = 0;
    bit           tx_burst = 1'b0;
    t_console_rsp tx_rsp;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_console(in_flight, tx_rsp);
                expected_rsps.push_back(tx_rsp);
                if ($urandom_range(99) == 0) tx_burst = !tx_burst;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (tx_gap > 0) begin
                    tx_gap = tx_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    in_flight = pending_reqs.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {3'b000, in_flight.addr, in_flight.trow,
                                      in_flight.tcol, in_flight.ch, in_flight.cmd};
                    tx_gap = pick_gap(tx_burst);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    t_console_rsp got_rsp;
    t_console_rsp want_rsp;
    int unsigned  rx_stall = 0;
    bit           rx_burst = 1'b0;
    logic         rx_ready_nxt;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got_rsp.col   = m_axis_tdata[6:0];
                got_rsp.row   = m_axis_tdata[11:7];
                got_rsp.lin   = m_axis_tdata[22:12];
                got_rsp.glyph = m_axis_tdata[38:23];
                if (expected_rsps.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= MAX_SHOWN)
                        $display("%0t: unexpected result col=%0d row=%0d lin=%0d data=%h",
                                 $realtime, got_rsp.col, got_rsp.row, got_rsp.lin,
                                 got_rsp.glyph);
                end else begin
                    want_rsp = expected_rsps.pop_front();
                    results_checked++;
                    if (got_rsp != want_rsp) begin
                        err_cnt++;
                        if (err_cnt <= MAX_SHOWN)
                            $display({"%0t: result %0d mismatch: exp col=%0d row=%0d lin=%0d ",
                                      "data=%h, got col=%0d row=%0d lin=%0d data=%h"},
                                     $realtime, results_checked, want_rsp.col, want_rsp.row,
                                     want_rsp.lin, want_rsp.glyph, got_rsp.col, got_rsp.row,
                                     got_rsp.lin, got_rsp.glyph);
                    end
                end
            end
            if ($urandom_range(499) == 0) rx_burst = !rx_burst;
            if (rx_stall > 0) begin
                rx_stall     = rx_stall - 1;
                rx_ready_nxt = 1'b0;
            end else if (!rx_burst && $urandom_range(99) < 15) begin
                rx_stall     = pick_gap(1'b0);
                rx_ready_nxt = 1'b0;
            end else begin
                rx_ready_nxt = 1'b1;
            end
            m_axis_tready <= rx_ready_nxt;
        end
    end

    task automatic issue(input t_console_req rq);
        pending_reqs.push_back(rq);
        reqs_issued++;
    endtask

    task automatic wait_drained();
        do @(negedge i_clk); while (results_checked != reqs_issued);
    endtask

    task automatic write_colour(input t_reg idx, input logic [3:0] value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        if (idx == REG_FG) fg_colour = value;
        else bg_colour = value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        logic [3:0] fg_plan [0:PHASES-1];
        logic [3:0] bg_plan [0:PHASES-1];
        fg_plan = '{4'd15, 4'd0, 4'd15, 4'd0, 4'd0, 4'd7};
        bg_plan = '{4'd15, 4'd0, 4'd0, 4'd15, 4'd0, 4'd0};
        fg_plan[4] = 4'($urandom_range(15));
        bg_plan[4] = 4'($urandom_range(15));
        fill_screen(0, {RESET_ATTR, CH_BLANK});
        cur_col   = 0;
        cur_row   = 0;
        fg_colour = 4'd7;
        bg_colour = 4'd0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed pass under reset colours
        @(negedge i_clk);
        issue(make_req(CMD_READ,  8'h00,  8'd0,   8'd0,   11'd0));
        issue(make_req(CMD_READ,  8'hFF,  8'hFF,  8'hFF,  11'd1999));
        issue(make_req(CMD_READ,  8'h00,  8'd0,   8'd0,   11'd2047));
        issue(make_req(CMD_PUT,   8'h41,  8'd0,   8'd0,   11'd0));
        issue(make_req(CMD_PUT,   8'hFF,  8'd0,   8'd0,   11'd0));
        issue(make_req(CMD_PUT,   8'h00,  8'd0,   8'd0,   11'd0));
        issue(make_req(CMD_PUT,   CH_BS,  8'd0,   8'd0,   11'd0));
        issue(make_req(CMD_PUT,   CH_TAB, 8'd0,   8'd0,   11'd0));
        issue(make_req(CMD_PUT,   CH_CR,  8'd0,   8'd0,   11'd0));
        issue(make_req(CMD_PUT,   CH_BS,  8'd0,   8'd0,   11'd0));   // no-op at col 0
        issue(make_req(CMD_SET,   8'h00,  8'hFF,  8'hFF,  11'd0));   // clamps to corner
        issue(make_req(CMD_PUT,   8'h5A,  8'd0,   8'd0,   11'd0));   // wrap into scroll
        issue(make_req(CMD_READ,  8'h00,  8'd0,   8'd0,   11'd1919));
        issue(make_req(CMD_SET,   8'h00,  8'd75,  8'd0,   11'd0));
        issue(make_req(CMD_PUT,   CH_TAB, 8'd0,   8'd0,   11'd0));   // tab wraps
        issue(make_req(CMD_SET,   8'h00,  8'd0,   8'd24,  11'd0));
        issue(make_req(CMD_PUT,   CH_LF,  8'd0,   8'd0,   11'd0));   // newline scroll
        issue(make_req(CMD_PUT,   8'h7F,  8'd0,   8'd0,   11'd0));
        issue(make_req(CMD_READ,  8'h00,  8'd0,   8'd0,   11'd1920));
        issue(make_req(CMD_CLEAR, 8'hFF,  8'hFF,  8'hFF,  11'h7FF));
        issue(make_req(CMD_READ,  8'h00,  8'd0,   8'd0,   11'd0));
        issue(make_req(CMD_SET,   8'h00,  8'd0,   8'd0,   11'd0));
        issue(make_req(CMD_READ,  8'h00,  8'd0,   8'd0,   11'd1999));
        wait_drained();

        for (int p = 0; p < PHASES; p++) begin
            write_colour(REG_FG, fg_plan[p]);
            write_colour(REG_BG, bg_plan[p]);
            @(negedge i_clk);
            for (int n = 0; n < PHASE_ITEMS; n++) issue(random_req());
            wait_drained();
        end

        repeat (3000) @(posedge i_clk);
        if (expected_rsps.size() != 0) err_cnt++;
        if (err_cnt == 0) begin
            $display("tb_text_console_cursor_scroll: PASS");
        end else begin
            $display("tb_text_console_cursor_scroll: FAIL");
        end
        $finish;
    end

    initial begin
        #(64'd300_000_000);
        $display("tb_text_console_cursor_scroll: FAIL");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/tccs_pkg.sv
hdl/tccs_ram.sv
hdl/tccs_cursor.sv
hdl/text_console_cursor_scroll.sv
tb/tb_text_console_cursor_scroll.sv
